@@ rtl/core/tpq_pkg.sv @@
`timescale 1ns / 1ps

package tpq_pkg;

  localparam int unsigned NODES       = 4096;
  localparam int unsigned LEVELS      = 12;
  localparam int unsigned ID_W        = 12;
  localparam int unsigned WEIGHT_W    = 31;
  localparam int unsigned DEPTH_W     = 12;
  localparam int unsigned LVL_W       = 4;
  localparam int unsigned ENTRIES     = NODES * LEVELS;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned IN_DATA_W   = 72;
  localparam int unsigned OUT_DATA_W  = 80;

  localparam logic [DEPTH_W-1:0]  DEPTH_MAX  = DEPTH_W'(NODES - 1);
  localparam logic [LVL_W-1:0]    LVL_TOP    = LVL_W'(LEVELS - 1);
  localparam logic [WEIGHT_W-1:0] WEIGHT_ALL = {WEIGHT_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_ROOT  = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [ID_W-1:0]     node_id;
    logic [ID_W-1:0]     parent_id;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [ID_W-1:0]     other_id;
  } req_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] path_min;
    logic [WEIGHT_W-1:0] path_max;
    logic                path_empty;
    logic [ID_W-1:0]     common_ancestor;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]     anc;
    logic [WEIGHT_W-1:0] lo;
    logic [WEIGHT_W-1:0] hi;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ROOT,
    S_ADD_DEP,
    S_ADD_L0,
    S_ADD_RD,
    S_ADD_WR,
    S_Q_DU,
    S_Q_DB,
    S_Q_SWAP,
    S_LIFT_RD,
    S_LIFT_DEP,
    S_LIFT_CMP,
    S_MEET,
    S_PAR_RA,
    S_PAR_RB,
    S_PAR_CMP,
    S_TOP_RD,
    S_TOP,
    S_LC_DEP,
    S_LEN,
    S_CLIMB,
    S_CLIMB_USE,
    S_OUT
  } state_e;

  // node * LEVELS + level, with LEVELS = 12 as shift-and-add
  function automatic logic [ADDR_W-1:0] ent_index(input logic [ID_W-1:0] n,
                                                  input logic [LVL_W-1:0] l);
    ent_index = ADDR_W'({n, 3'b000}) + ADDR_W'({n, 2'b00}) + ADDR_W'(l);
  endfunction

endpackage

@@ rtl/core/tpq_engine.sv @@
`timescale 1ns / 1ps

module tpq_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  tpq_pkg::req_t req_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output tpq_pkg::res_t res_o
);

  localparam logic [tpq_pkg::LVL_W-1:0] LVL_ONE = tpq_pkg::LVL_W'(1);

  // lifting table and depth table, one access per cycle each, registered read
  tpq_pkg::entry_t             ent_mem [tpq_pkg::ENTRIES];
  logic [tpq_pkg::DEPTH_W-1:0] dep_mem [tpq_pkg::NODES];

  logic [tpq_pkg::ADDR_W-1:0]  ent_addr;
  logic                        ent_we;
  tpq_pkg::entry_t             ent_wdata;
  tpq_pkg::entry_t             ent_rdata_q;
  logic [tpq_pkg::ID_W-1:0]    dep_addr;
  logic                        dep_we;
  logic [tpq_pkg::DEPTH_W-1:0] dep_wdata;
  logic [tpq_pkg::DEPTH_W-1:0] dep_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_addr] <= ent_wdata;
    end
    ent_rdata_q <= ent_mem[ent_addr];
  end

  always_ff @(posedge clk_i) begin
    if (dep_we) begin
      dep_mem[dep_addr] <= dep_wdata;
    end
    dep_rdata_q <= dep_mem[dep_addr];
  end

  tpq_pkg::state_e st_q, st_d;
  tpq_pkg::kind_e  kind_q, kind_d;
  logic [tpq_pkg::ID_W-1:0]     u0_q, u0_d, b0_q, b0_d, par_q, par_d;
  logic [tpq_pkg::ID_W-1:0]     a_q, a_d, b_q, b_d, tmp_q, tmp_d, lc_q, lc_d;
  logic [tpq_pkg::WEIGHT_W-1:0] w_q, w_d, lo_q, lo_d, hi_q, hi_d;
  logic [tpq_pkg::DEPTH_W-1:0]  du0_q, du0_d, db0_q, db0_d, dbs_q, dbs_d;
  logic [tpq_pkg::DEPTH_W-1:0]  len_q, len_d, lenb_q, lenb_d;
  logic [tpq_pkg::LVL_W-1:0]    lvl_q, lvl_d;
  logic                         pass_q, pass_d;
  tpq_pkg::entry_t              prev_q, prev_d;
  tpq_pkg::res_t                res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= tpq_pkg::S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    u0_q   <= u0_d;
    b0_q   <= b0_d;
    par_q  <= par_d;
    a_q    <= a_d;
    b_q    <= b_d;
    tmp_q  <= tmp_d;
    lc_q   <= lc_d;
    w_q    <= w_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    du0_q  <= du0_d;
    db0_q  <= db0_d;
    dbs_q  <= dbs_d;
    len_q  <= len_d;
    lenb_q <= lenb_d;
    lvl_q  <= lvl_d;
    pass_q <= pass_d;
    prev_q <= prev_d;
    res_q  <= res_d;
  end

  always_comb begin
    st_d      = st_q;
    kind_d    = kind_q;
    u0_d      = u0_q;
    b0_d      = b0_q;
    par_d     = par_q;
    a_d       = a_q;
    b_d       = b_q;
    tmp_d     = tmp_q;
    lc_d      = lc_q;
    w_d       = w_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    du0_d     = du0_q;
    db0_d     = db0_q;
    dbs_d     = dbs_q;
    len_d     = len_q;
    lenb_d    = lenb_q;
    lvl_d     = lvl_q;
    pass_d    = pass_q;
    prev_d    = prev_q;
    res_d     = res_q;
    ent_addr  = tpq_pkg::ent_index(a_q, lvl_q);
    ent_we    = 1'b0;
    ent_wdata = prev_q;
    dep_addr  = a_q;
    dep_we    = 1'b0;
    dep_wdata = '0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    unique case (st_q)
      tpq_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          kind_d = req_i.kind;
          u0_d   = req_i.node_id;
          par_d  = req_i.parent_id;
          w_d    = req_i.edge_weight;
          b0_d   = req_i.other_id;
          lvl_d  = '0;
          case (req_i.kind)
            tpq_pkg::KIND_ROOT: st_d = tpq_pkg::S_ROOT;
            tpq_pkg::KIND_ADD:  st_d = tpq_pkg::S_ADD_DEP;
            tpq_pkg::KIND_QUERY: begin
              if (req_i.node_id == req_i.other_id) begin
                res_d = '{path_min: '0, path_max: '0, path_empty: 1'b1,
                          common_ancestor: req_i.node_id};
                st_d  = tpq_pkg::S_OUT;
              end else begin
                st_d = tpq_pkg::S_Q_DU;
              end
            end
            default: st_d = tpq_pkg::S_IDLE; // drop unknown kind
          endcase
        end
      end

      tpq_pkg::S_ROOT: begin
        ent_addr  = tpq_pkg::ent_index(u0_q, lvl_q);
        ent_we    = 1'b1;
        ent_wdata = '{anc: u0_q, lo: '0, hi: '0};
        dep_addr  = u0_q;
        dep_we    = (lvl_q == '0);
        dep_wdata = '0;
        lvl_d     = lvl_q + 1'b1;
        if (lvl_q == tpq_pkg::LVL_TOP) begin
          st_d = tpq_pkg::S_IDLE;
        end
      end

      tpq_pkg::S_ADD_DEP: begin
        dep_addr = par_q;
        st_d     = tpq_pkg::S_ADD_L0;
      end

      tpq_pkg::S_ADD_L0: begin
        dep_addr  = u0_q;
        dep_we    = 1'b1;
        dep_wdata = (dep_rdata_q >= tpq_pkg::DEPTH_MAX) ? tpq_pkg::DEPTH_MAX
                                                        : dep_rdata_q + 1'b1;
        ent_addr  = tpq_pkg::ent_index(u0_q, '0);
        ent_we    = 1'b1;
        ent_wdata = '{anc: par_q, lo: w_q, hi: w_q};
        prev_d    = '{anc: par_q, lo: w_q, hi: w_q};
        lvl_d     = LVL_ONE;
        st_d      = (tpq_pkg::LEVELS == 1) ? tpq_pkg::S_IDLE : tpq_pkg::S_ADD_RD;
      end

      tpq_pkg::S_ADD_RD: begin
        ent_addr = tpq_pkg::ent_index(prev_q.anc, lvl_q - 1'b1);
        st_d     = tpq_pkg::S_ADD_WR;
      end

      tpq_pkg::S_ADD_WR: begin
        ent_wdata.anc = ent_rdata_q.anc;
        ent_wdata.lo  = (ent_rdata_q.lo < prev_q.lo) ? ent_rdata_q.lo : prev_q.lo;
        ent_wdata.hi  = (ent_rdata_q.hi > prev_q.hi) ? ent_rdata_q.hi : prev_q.hi;
        ent_addr      = tpq_pkg::ent_index(u0_q, lvl_q);
        ent_we        = 1'b1;
        prev_d        = ent_wdata;
        lvl_d         = lvl_q + 1'b1;
        if (lvl_q == tpq_pkg::LVL_TOP) begin
          st_d = tpq_pkg::S_IDLE;
        end else begin
          st_d = tpq_pkg::S_ADD_RD;
        end
      end

      tpq_pkg::S_Q_DU: begin
        dep_addr = u0_q;
        st_d     = tpq_pkg::S_Q_DB;
      end

      tpq_pkg::S_Q_DB: begin
        dep_addr = b0_q;
        du0_d    = dep_rdata_q;
        st_d     = tpq_pkg::S_Q_SWAP;
      end

      tpq_pkg::S_Q_SWAP: begin
        db0_d = dep_rdata_q;
        // walk up from the deeper endpoint
        if (du0_q < dep_rdata_q) begin
          a_d   = b0_q;
          b_d   = u0_q;
          dbs_d = du0_q;
        end else begin
          a_d   = u0_q;
          b_d   = b0_q;
          dbs_d = dep_rdata_q;
        end
        lvl_d = tpq_pkg::LVL_TOP;
        st_d  = tpq_pkg::S_LIFT_RD;
      end

      tpq_pkg::S_LIFT_RD: begin
        ent_addr = tpq_pkg::ent_index(a_q, lvl_q);
        st_d     = tpq_pkg::S_LIFT_DEP;
      end

      tpq_pkg::S_LIFT_DEP: begin
        dep_addr = ent_rdata_q.anc;
        tmp_d    = ent_rdata_q.anc;
        st_d     = tpq_pkg::S_LIFT_CMP;
      end

      tpq_pkg::S_LIFT_CMP: begin
        if (dep_rdata_q >= dbs_q) begin
          a_d = tmp_q;
        end
        lvl_d = lvl_q - 1'b1;
        st_d  = (lvl_q == '0) ? tpq_pkg::S_MEET : tpq_pkg::S_LIFT_RD;
      end

      tpq_pkg::S_MEET: begin
        lc_d  = a_q;
        lvl_d = tpq_pkg::LVL_TOP;
        st_d  = (a_q == b_q) ? tpq_pkg::S_LC_DEP : tpq_pkg::S_PAR_RA;
      end

      tpq_pkg::S_PAR_RA: begin
        ent_addr = tpq_pkg::ent_index(a_q, lvl_q);
        st_d     = tpq_pkg::S_PAR_RB;
      end

      tpq_pkg::S_PAR_RB: begin
        ent_addr = tpq_pkg::ent_index(b_q, lvl_q);
        tmp_d    = ent_rdata_q.anc;
        st_d     = tpq_pkg::S_PAR_CMP;
      end

      tpq_pkg::S_PAR_CMP: begin
        if (tmp_q != ent_rdata_q.anc) begin
          a_d = tmp_q;
          b_d = ent_rdata_q.anc;
        end
        lvl_d = lvl_q - 1'b1;
        st_d  = (lvl_q == '0) ? tpq_pkg::S_TOP_RD : tpq_pkg::S_PAR_RA;
      end

      tpq_pkg::S_TOP_RD: begin
        ent_addr = tpq_pkg::ent_index(a_q, '0);
        st_d     = tpq_pkg::S_TOP;
      end

      tpq_pkg::S_TOP: begin
        lc_d = ent_rdata_q.anc;
        st_d = tpq_pkg::S_LC_DEP;
      end

      tpq_pkg::S_LC_DEP: begin
        dep_addr = lc_q;
        st_d     = tpq_pkg::S_LEN;
      end

      tpq_pkg::S_LEN: begin
        len_d  = (du0_q > dep_rdata_q) ? du0_q - dep_rdata_q : '0;
        lenb_d = (db0_q > dep_rdata_q) ? db0_q - dep_rdata_q : '0;
        a_d    = u0_q;
        lo_d   = tpq_pkg::WEIGHT_ALL;
        hi_d   = '0;
        lvl_d  = tpq_pkg::LVL_TOP;
        pass_d = 1'b0;
        st_d   = tpq_pkg::S_CLIMB;
      end

      tpq_pkg::S_CLIMB, tpq_pkg::S_CLIMB_USE: begin
        ent_addr = tpq_pkg::ent_index(a_q, lvl_q);
        if (st_q == tpq_pkg::S_CLIMB_USE) begin
          if (ent_rdata_q.lo < lo_q) lo_d = ent_rdata_q.lo;
          if (ent_rdata_q.hi > hi_q) hi_d = ent_rdata_q.hi;
          a_d  = ent_rdata_q.anc;
          st_d = tpq_pkg::S_CLIMB;
          // advance past the level just used
          if (lvl_q == '0) begin
            st_d = tpq_pkg::S_CLIMB;
          end
        end
        if (st_q == tpq_pkg::S_CLIMB && len_q[lvl_q]) begin
          st_d = tpq_pkg::S_CLIMB_USE;
        end else if (lvl_q != '0) begin
          lvl_d = lvl_q - 1'b1;
          st_d  = tpq_pkg::S_CLIMB;
        end else if (!pass_q) begin
          pass_d = 1'b1;
          a_d    = b0_q;
          len_d  = lenb_q;
          lvl_d  = tpq_pkg::LVL_TOP;
          st_d   = tpq_pkg::S_CLIMB;
        end else begin
          res_d.path_min        = (st_q == tpq_pkg::S_CLIMB_USE) ? lo_d : lo_q;
          res_d.path_max        = (st_q == tpq_pkg::S_CLIMB_USE) ? hi_d : hi_q;
          res_d.path_empty      = 1'b0;
          res_d.common_ancestor = lc_q;
          st_d                  = tpq_pkg::S_OUT;
        end
      end

      tpq_pkg::S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          st_d = tpq_pkg::S_IDLE;
        end
      end

      default: st_d = tpq_pkg::S_IDLE;
    endcase
  end

  assign res_o = res_q;

endmodule

@@ rtl/core/tree_path_min_max_query.sv @@
`timescale 1ns / 1ps

// Binary-lifting path query over a weighted rooted tree of up to 4096 nodes.
// Send items on the s_axis side: tuser selects set-root, add-child or query.
// Parents must be added before their children. Only queries return a result
// on the m_axis side. All work runs through one single-port lifting table and
// one depth table, one access per cycle each, so the block takes one item at
// a time. The work of a query depends on whether one endpoint is an
// ancestor of the other and on the number of set bits in the two climb
// lengths. A finished result waits in the output register while the next
// item is accepted.
module tree_path_min_max_query (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // node_id, parent_id, edge_weight, other_id, zero pad
  input  logic [tpq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // path_min, path_max, common_ancestor, zero pad
  output logic [tpq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // path_empty
  output logic                             m_axis_tuser
);

  localparam int unsigned PACK_W = 2 * tpq_pkg::WEIGHT_W + tpq_pkg::ID_W;

  tpq_pkg::req_t req;
  tpq_pkg::res_t res;
  tpq_pkg::res_t out_q;
  logic          out_valid_q;
  logic          res_valid;
  logic          res_ready;

  assign req.kind        = tpq_pkg::kind_e'(s_axis_tuser);
  assign req.node_id     = s_axis_tdata[11:0];
  assign req.parent_id   = s_axis_tdata[23:12];
  assign req.edge_weight = s_axis_tdata[54:24];
  assign req.other_id    = s_axis_tdata[66:55];

  tpq_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register frees as its transfer completes
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.path_empty;
  assign m_axis_tdata  = {(tpq_pkg::OUT_DATA_W - PACK_W)'(0), out_q.common_ancestor,
                          out_q.path_max, out_q.path_min};

endmodule
